// File: rtl/core/bha_pkg.sv
// Package for the bitmap handle allocator: map geometry, request/response words,
// opcode and status codes, and the controller/datapath command and status structs.
// No dependencies.
package bha_pkg;

    localparam int NUM_HANDLES = 65536;
    // Must be a power of two: handles split into word index and bit index by bit slicing.
    localparam int WORD_BITS   = 64;
    localparam int MAP_WORDS   = (NUM_HANDLES + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int HANDLE_W    = 16;
    // Handles that fit in the last word; the rest of that word stays clear.
    localparam int LAST_BITS   = NUM_HANDLES - (MAP_WORDS - 1) * WORD_BITS;

    localparam logic OP_ALLOC     = 1'b0;
    localparam logic OP_FREE      = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [HANDLE_W-1:0] handle_in;
    } bha_req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic                status;
    } bha_rsp_t;

    typedef struct packed {
        logic clr_wr;       // write reset pattern at current address
        logic addr_zero;    // point at word 0
        logic addr_handle;  // point at word of the request handle
        logic addr_inc;     // step to next word
        logic rd_en;        // read word at the new address
        logic latch_req;    // capture request word
        logic wr_alloc;     // write back word with lowest free bit cleared
        logic wr_rel;       // write back word with released bit set
        logic emit_alloc;
        logic emit_fail;
        logic emit_rel;
    } bha_cmd_t;

    typedef struct packed {
        logic addr_last;    // current address is the last map word
        logic word_nz;      // word read last cycle has a free bit
    } bha_stat_t;

    // Reset value of one map word: every real handle free.
    function automatic logic [WORD_BITS-1:0] word_valid_mask(input logic [WADDR_W-1:0] w);
        logic [WORD_BITS-1:0] m;
        m = '1;
        if (32'(w) == 32'(MAP_WORDS - 1))
        begin
            m = WORD_BITS'((65'(1) << LAST_BITS) - 65'(1));
        end
        return m;
    endfunction

endpackage

// File: rtl/core/bha_ctrl.sv
// Controller FSM for the bitmap handle allocator: reset clear pass, word scan
// on allocate, read-modify-write on release. Depends on bha_pkg.
module bha_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              opcode,
    input  bha_pkg::bha_stat_t stat,
    output bha_pkg::bha_cmd_t  cmd,
    output logic              busy
);
    import bha_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_ALLOC = 3'd3;
    localparam logic [2:0] S_REL   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr   = 1'b1;
                cmd.addr_inc = 1'b1;
                if (stat.addr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch_req = 1'b1;
                    cmd.rd_en     = 1'b1;
                    if (opcode == OP_ALLOC)
                    begin
                        cmd.addr_zero = 1'b1;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        cmd.addr_handle = 1'b1;
                        state_next      = S_REL;
                    end
                end
            end
            S_SCAN:
            begin
                priority if (stat.word_nz)
                begin
                    state_next = S_ALLOC;
                end
                else if (stat.addr_last)
                begin
                    cmd.emit_fail = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.addr_inc = 1'b1;
                    cmd.rd_en    = 1'b1;
                end
            end
            S_ALLOC:
            begin
                cmd.wr_alloc   = 1'b1;
                cmd.emit_alloc = 1'b1;
                state_next     = S_IDLE;
            end
            S_REL:
            begin
                cmd.wr_rel   = 1'b1;
                cmd.emit_rel = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: rtl/core/bha_datapath.sv
// Datapath for the bitmap handle allocator: free map memory, word address
// counter, lowest-set-bit encoder and response registers. Depends on bha_pkg.
module bha_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  bha_pkg::bha_req_t  req,
    input  bha_pkg::bha_cmd_t  cmd,
    output bha_pkg::bha_stat_t stat,
    output logic              done,
    output bha_pkg::bha_rsp_t  rsp
);
    import bha_pkg::*;

    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];

    logic [WADDR_W-1:0]   addr_reg;
    logic [WADDR_W-1:0]   addr_next;
    logic [WORD_BITS-1:0] rd_data_reg;
    bha_req_t             req_reg;
    logic                 done_reg;
    bha_rsp_t             rsp_reg;

    logic [BIT_W-1:0]     req_bit;
    logic                 req_in_range;
    logic [BIT_W-1:0]     low_bit;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;

    // Lowest set bit; scanned from the top so the lowest one wins.
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    assign req_bit      = req_reg.handle_in[BIT_W-1:0];
    assign req_in_range = (32'(req_reg.handle_in) < 32'(NUM_HANDLES));
    assign low_bit      = lowest_set(rd_data_reg);

    always_comb
    begin
        priority if (cmd.addr_zero)
        begin
            addr_next = '0;
        end
        else if (cmd.addr_handle)
        begin
            addr_next = WADDR_W'(32'(req.handle_in) >> BIT_W);
        end
        else if (cmd.addr_inc)
        begin
            addr_next = (addr_reg == WADDR_W'(MAP_WORDS - 1)) ? '0 : addr_reg + 1'b1;
        end
        else
        begin
            addr_next = addr_reg;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = rd_data_reg;
        priority if (cmd.clr_wr)
        begin
            wr_en   = 1'b1;
            wr_data = word_valid_mask(addr_reg);
        end
        else if (cmd.wr_alloc)
        begin
            wr_en   = 1'b1;
            wr_data = rd_data_reg & ~(WORD_BITS'(1) << low_bit);
        end
        else if (cmd.wr_rel)
        begin
            wr_en   = req_in_range;
            wr_data = rd_data_reg | (WORD_BITS'(1) << req_bit);
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[addr_reg] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= map_mem[addr_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            addr_reg <= addr_next;
            done_reg <= cmd.emit_alloc | cmd.emit_fail | cmd.emit_rel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_reg <= req;
        end
        priority if (cmd.emit_alloc)
        begin
            rsp_reg.handle_out <= HANDLE_W'((32'(addr_reg) << BIT_W) | 32'(low_bit));
            rsp_reg.status     <= STATUS_OK;
        end
        else if (cmd.emit_fail)
        begin
            rsp_reg.handle_out <= '0;
            rsp_reg.status     <= STATUS_EMPTY;
        end
        else if (cmd.emit_rel)
        begin
            rsp_reg.handle_out <= req_reg.handle_in;
            rsp_reg.status     <= STATUS_OK;
        end
        else
        begin
            rsp_reg <= rsp_reg;
        end
    end

    assign stat.addr_last = (addr_reg == WADDR_W'(MAP_WORDS - 1));
    assign stat.word_nz   = |rd_data_reg;
    assign done           = done_reg;
    assign rsp            = rsp_reg;

endmodule

// File: rtl/core/bitmap_handle_allocator.sv
// Top level of the bitmap handle allocator: controller FSM plus datapath.
// Depends on bha_pkg, bha_ctrl and bha_datapath.
//
// Usage: after reset the block runs a clear pass over all MAP_WORDS (1024) words that marks
// every handle free; busy stays high throughout and no word is taken. A request word
// is taken on a clock edge with start high and busy low. An allocate scans the free map
// one 64-bit word per cycle from word 0 through a registered-read memory, so busy stays
// high until the first word with a free handle has been found and written back (or until
// all 1024 words have been scanned when the map is empty, reported as status 1 with
// handle 0). A release is a read-modify-write of one word; a handle already free
// is left alone and echoed with status 0. The response word appears on rsp for exactly
// one cycle with done high, the first cycle in which busy is low again; the receiver
// cannot stall it, so it must capture rsp whenever done is high. A new request may be
// given in that cycle.
module bitmap_handle_allocator (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  bha_pkg::bha_req_t req,
    output logic             busy,
    output logic             done,
    output bha_pkg::bha_rsp_t rsp
);
    import bha_pkg::*;

    bha_cmd_t  cmd;
    bha_stat_t stat;

    // Sequencing: clear pass, scan loop, write-back and response timing.
    bha_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (req.opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Free map storage and the word/bit arithmetic.
    bha_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

// File: sim/bha_checker.sv
`timescale 1ns / 1ps
// Response checker for bitmap_handle_allocator: keeps its own free map, predicts
// one response word per accepted request word and compares them in order.
// Depends on bha_pkg.
module bha_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  bha_pkg::bha_req_t req,
    input  logic              done,
    input  bha_pkg::bha_rsp_t rsp,
    output int                fail_count,
    output int                pending
);
    import bha_pkg::*;

    logic [WORD_BITS-1:0] free_bits [MAP_WORDS];
    // Every word below scan_floor is known to be all zero.
    int                   scan_floor;
    bha_rsp_t             expected_rsp [$];
    bha_rsp_t             want;
    int                   errors;

    function automatic logic [WORD_BITS-1:0] fresh_word(input int w);
        int                 room;
        logic [WORD_BITS:0] ones;
        room = NUM_HANDLES - w * WORD_BITS;
        if (room >= WORD_BITS)
        begin
            return '1;
        end
        if (room <= 0)
        begin
            return '0;
        end
        ones       = '0;
        ones[room] = 1'b1;
        ones       = ones - 1'b1;
        return ones[WORD_BITS-1:0];
    endfunction

    // Applies one request word to the mirrored map and returns the response word.
    function automatic bha_rsp_t grant_or_return(input bha_req_t r);
        bha_rsp_t res;
        int       w;
        int       b;
        res.handle_out = r.handle_in;
        res.status     = STATUS_OK;
        if (r.opcode == OP_FREE)
        begin
            if (32'(r.handle_in) < NUM_HANDLES)
            begin
                w = 32'(r.handle_in) / WORD_BITS;
                b = 32'(r.handle_in) % WORD_BITS;
                free_bits[w][b] = 1'b1;
                if (w < scan_floor)
                begin
                    scan_floor = w;
                end
            end
            return res;
        end
        for (w = scan_floor; w < MAP_WORDS; w++)
        begin
            if (free_bits[w] != '0)
            begin
                break;
            end
        end
        scan_floor = w;
        if (w == MAP_WORDS)
        begin
            res.handle_out = '0;
            res.status     = STATUS_EMPTY;
            return res;
        end
        for (b = 0; b < WORD_BITS; b++)
        begin
            if (free_bits[w][b])
            begin
                break;
            end
        end
        free_bits[w][b] = 1'b0;
        res.handle_out  = HANDLE_W'(w * WORD_BITS + b);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < MAP_WORDS; w++)
            begin
                free_bits[w] = fresh_word(w);
            end
            scan_floor = 0;
            errors     = 0;
            expected_rsp.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // Retire first: a new word may be taken on the edge that ends a result.
            if (done)
            begin
                if (expected_rsp.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("%t: stray result: handle %0d status %0d", $realtime,
                                 rsp.handle_out, rsp.status);
                    end
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.handle_out !== want.handle_out || rsp.status !== want.status)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%t: mismatch: expected %0d/%0d, got %0d/%0d",
                                     $realtime, want.handle_out, want.status,
                                     rsp.handle_out, rsp.status);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                expected_rsp.push_back(grant_or_return(req));
            end
            fail_count <= errors;
            pending    <= expected_rsp.size();
        end
    end

endmodule

// File: sim/bitmap_handle_allocator_tb.sv
`timescale 1ns / 1ps
// Testbench top for bitmap_handle_allocator: makes the request words and gives the verdict.
// Depends on bha_pkg, bha_checker and the allocator RTL.
module bitmap_handle_allocator_tb;
    import bha_pkg::*;

    // Longest quiet stretch of a correct run is the post-reset clear pass or a full
    // scan of an empty map plus a sender gap; allow plenty more.
    localparam int STALL_LIMIT  = 8192;
    localparam int RANDOM_WORDS = 530;
    localparam int TAIL_WORDS   = 24;

    logic     clk;
    logic     rst_n;
    logic     start;
    bha_req_t req;
    logic     busy;
    logic     done;
    bha_rsp_t rsp;
    int       fail_count;
    int       pending;

    // Stimulus bookkeeping, fed from the response port.
    logic [HANDLE_W-1:0] live_handles [$];
    logic                ops_in_flight [$];
    logic                retired_op;
    int                  n_alloc        = 0;
    int                  n_release      = 0;
    int                  n_empty        = 0;
    int                  idle_cycles    = 0;
    logic                idle_on;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    bitmap_handle_allocator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    bha_checker resp_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Track which handles are held so releases can target them. At most one word
    // is in flight, so results pair with accepted ops in order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done && ops_in_flight.size() != 0)
            begin
                retired_op = ops_in_flight.pop_front();
                if (retired_op == OP_ALLOC && rsp.status == STATUS_OK)
                begin
                    live_handles.push_back(rsp.handle_out);
                end
                if (retired_op == OP_ALLOC && rsp.status == STATUS_EMPTY)
                begin
                    n_empty++;
                end
            end
            if (start && !busy)
            begin
                ops_in_flight.push_back(req.opcode);
                if (req.opcode == OP_ALLOC)
                begin
                    n_alloc++;
                end
                else
                begin
                    n_release++;
                end
            end
        end
    end

    // Watchdog: any accepted request or result word counts as progress.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Drive one request word at the falling edge and hold it until taken.
    task automatic issue(input logic op, input logic [HANDLE_W-1:0] h);
        @(negedge clk);
        start <= 1'b1;
        req   <= {op, h};
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    task automatic pause_sender(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Hold off until every outstanding response word has come back.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        int                  pick;
        int                  slot;
        logic                op;
        logic [HANDLE_W-1:0] h;

        rst_n   = 1'b0;
        start   = 1'b0;
        req     = '0;
        idle_on = 1'b1;
        repeat (3)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: first handles, reuse of the lowest freed handle, releases of
        // handles already free (both field extremes), alternating bit patterns,
        // word boundaries. The first word waits out the clear pass.
        issue(OP_ALLOC, 16'h0000);
        issue(OP_ALLOC, 16'h0000);
        issue(OP_FREE,  16'h0000);
        issue(OP_FREE,  16'h0000);
        issue(OP_ALLOC, 16'hFFFF);
        issue(OP_FREE,  16'hFFFF);
        issue(OP_ALLOC, 16'h1234);
        issue(OP_FREE,  16'h5555);
        issue(OP_FREE,  16'hAAAA);
        issue(OP_FREE,  16'h0001);
        issue(OP_ALLOC, 16'h0000);
        issue(OP_FREE,  16'h003F);
        issue(OP_FREE,  16'h0040);
        issue(OP_FREE,  16'h0002);
        issue(OP_ALLOC, 16'h0000);
        issue(OP_ALLOC, 16'h0000);
        drain();

        // Random mix: mostly allocations and releases of held handles, with
        // releases of arbitrary handles as noise (usually already free).
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 40 == 0)
            begin
                idle_on = ($urandom_range(0, 2) != 0);
            end
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                pause_sender($urandom_range(1, 9));
            end
            if (i == RANDOM_WORDS / 2)
            begin
                drain();
            end
            pick = $urandom_range(0, 99);
            @(negedge clk);
            if (pick < 55)
            begin
                op = OP_ALLOC;
                h  = HANDLE_W'($urandom);
            end
            else if (pick < 90 && live_handles.size() != 0)
            begin
                op   = OP_FREE;
                slot = $urandom_range(0, live_handles.size() - 1);
                h    = live_handles[slot];
                // Now and then keep it listed so a later release hits a free handle.
                if (pick < 86)
                begin
                    live_handles.delete(slot);
                end
            end
            else
            begin
                op = OP_FREE;
                h  = HANDLE_W'($urandom);
            end
            start <= 1'b1;
            req   <= {op, h};
            do
            begin
                @(posedge clk);
            end
            while (busy);
        end
        drain();

        // Last stretch, back to back with no sender gaps: allocates that walk
        // deeper into the map, then releases scattered across the map and
        // allocates that must find them again lowest first.
        idle_on = 1'b0;
        for (int k = 0; k < TAIL_WORDS; k++)
        begin
            issue(OP_ALLOC, HANDLE_W'($urandom));
        end
        h = HANDLE_W'($urandom);
        issue(OP_ALLOC, 16'hFFFF);
        issue(OP_FREE,  16'hFFFF);
        issue(OP_FREE,  16'h0000);
        issue(OP_FREE,  h);
        issue(OP_FREE,  16'h8000);
        issue(OP_FREE,  16'h0000);
        repeat (5)
        begin
            issue(OP_ALLOC, HANDLE_W'($urandom));
        end
        drain();
        repeat (8)
        begin
            @(negedge clk);
        end

        $display("Run covered %0d request words: %0d allocates (%0d failed), %0d releases.",
                 n_alloc + n_release, n_alloc, n_empty, n_release);
        $display("Releases mixed held handles, handles already free and random handles.");
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
